[rtl/core/uvlt_pkg.sv]
// Shared types and constants for the unique value list table.
package uvlt_pkg;

    // Field widths of the stream payloads.
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int FOUND_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int CAP_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADIDX   = 3'd5;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted transaction
        logic step;    // advance the walk over the list by one entry
        logic settle;  // commit the outcome and latch the result
        logic emit;    // move the latched result into the output register
    } uvlt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic instant;    // the outcome is known without a walk
        logic use_shift;  // the walk is a compacting shift, not a search
        logic walk_done;  // the current walk has finished
    } uvlt_stat_t;

endpackage

[rtl/core/uvlt_dpath.sv]
// Datapath of the unique value list table: entry memory, count, walk and result registers.
module uvlt_dpath #(
    parameter int DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  uvlt_pkg::uvlt_cmd_t             cmd_i,
    output uvlt_pkg::uvlt_stat_t            stat_o,
    // s_tuser fields from bit 0 up: cmd[1:0]
    input  logic [uvlt_pkg::CMD_W-1:0]      s_tuser,
    // s_tdata fields from bit 0 up: value[31:0], index[37:32], zero fill [39:38]
    input  logic [uvlt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            cfg_we,
    input  logic [uvlt_pkg::CAP_W-1:0]      cfg_wdata,
    // m_tdata fields from bit 0 up: status[2:0], found_index[8:3], entry_count[15:9]
    output logic [uvlt_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > uvlt_pkg::CAP_W) ? CW : uvlt_pkg::CAP_W;

    // Entry storage; contents are undefined until written.
    logic [uvlt_pkg::VALUE_W-1:0]  entry_mem [DEPTH];

    logic [uvlt_pkg::CMD_W-1:0]    op_reg;
    logic [uvlt_pkg::VALUE_W-1:0]  key_reg;
    logic [uvlt_pkg::INDEX_W-1:0]  idx_reg;
    logic [CW-1:0]                 ptr_reg;
    logic [CW-1:0]                 tag_reg;
    logic                          pend_reg;
    logic [uvlt_pkg::VALUE_W-1:0]  rd_data_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic [uvlt_pkg::CAP_W-1:0]    cap_reg;
    logic [uvlt_pkg::STATUS_W-1:0] res_status_reg;
    logic [uvlt_pkg::STATUS_W-1:0] res_status_next;
    logic [uvlt_pkg::FOUND_W-1:0]  res_found_reg;
    logic [uvlt_pkg::FOUND_W-1:0]  res_found_next;
    logic [uvlt_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [uvlt_pkg::INDEX_W-1:0]  s_index;
    logic [WW-1:0]                 cap_w;
    logic [WW-1:0]                 eff_cap;
    logic [WW-1:0]                 count_w;
    logic                          is_full;
    logic                          is_zero;
    logic                          bad_idx;
    logic                          more;
    logic                          hit;
    logic                          ins_wr;
    logic                          shift_wr;
    logic                          ins_wr_en;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [uvlt_pkg::VALUE_W-1:0]  wr_data;

    assign s_index = s_tdata[uvlt_pkg::VALUE_W +: uvlt_pkg::INDEX_W];

    // Capacity clamped to the storage depth, and the checks made before a walk.
    assign cap_w   = WW'(cap_reg);
    assign eff_cap = (cap_w > WW'(DEPTH)) ? WW'(DEPTH) : cap_w;
    assign count_w = WW'(count_reg);
    assign is_full = (count_w >= eff_cap);
    assign is_zero = (key_reg == '0);
    assign bad_idx = (WW'(idx_reg) >= count_w);

    // Walk progress: a read is in flight while pend_reg is set.
    assign more = (ptr_reg < count_reg);
    assign hit  = pend_reg && (rd_data_reg == key_reg);

    // Status toward the controller.
    always_comb begin
        stat_o.use_shift = (op_reg == uvlt_pkg::CMD_REMOVE);
        if (op_reg == uvlt_pkg::CMD_REMOVE) begin
            stat_o.walk_done = !pend_reg && !more;
        end else begin
            stat_o.walk_done = hit || (!pend_reg && !more);
        end
        case (op_reg)
            uvlt_pkg::CMD_INSERT: stat_o.instant = is_full || is_zero;
            uvlt_pkg::CMD_LOOKUP: stat_o.instant = 1'b0;
            uvlt_pkg::CMD_REMOVE: stat_o.instant = bad_idx;
            default:              stat_o.instant = 1'b1;
        endcase
    end

    // Outcome of the command once its walk is over.
    always_comb begin
        res_status_next = uvlt_pkg::ST_OK;
        res_found_next  = '0;
        count_next      = count_reg;
        ins_wr          = 1'b0;
        case (op_reg)
            uvlt_pkg::CMD_INSERT: begin
                if (is_full) begin
                    res_status_next = uvlt_pkg::ST_FULL;
                end else if (is_zero) begin
                    res_status_next = uvlt_pkg::ST_ZERO;
                end else if (hit) begin
                    res_status_next = uvlt_pkg::ST_DUP;
                end else begin
                    ins_wr     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            uvlt_pkg::CMD_LOOKUP: begin
                if (hit) begin
                    res_found_next = uvlt_pkg::FOUND_W'(tag_reg);
                end else begin
                    res_status_next = uvlt_pkg::ST_NOTFOUND;
                end
            end
            uvlt_pkg::CMD_REMOVE: begin
                if (bad_idx) begin
                    res_status_next = uvlt_pkg::ST_BADIDX;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // One write port: shifted entries during a remove, the new key at an insert.
    assign shift_wr  = cmd_i.step && pend_reg && (op_reg == uvlt_pkg::CMD_REMOVE);
    assign ins_wr_en = cmd_i.settle && ins_wr;
    assign wr_en     = shift_wr || ins_wr_en;
    assign wr_addr   = shift_wr ? AW'(tag_reg - CW'(1)) : AW'(count_reg);
    assign wr_data   = shift_wr ? rd_data_reg : key_reg;

    // Entry memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd_i.step && more) begin
            rd_data_reg <= entry_mem[ptr_reg[AW-1:0]];
        end
    end

    // Control state: count, capacity and the in-flight read flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= uvlt_pkg::CAP_RESET;
            pend_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (cmd_i.settle) begin
                count_reg <= count_next;
            end
            if (cmd_i.load) begin
                pend_reg <= 1'b0;
            end else if (cmd_i.step) begin
                pend_reg <= more;
            end
        end
    end

    // Transaction capture, walk pointers and result registers.
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[uvlt_pkg::VALUE_W-1:0];
            idx_reg <= s_index;
            if (s_tuser == uvlt_pkg::CMD_REMOVE) begin
                ptr_reg <= CW'(7'(s_index) + 7'd1);
            end else begin
                ptr_reg <= '0;
            end
        end else if (cmd_i.step && more) begin
            ptr_reg <= ptr_reg + CW'(1);
            tag_reg <= ptr_reg;
        end
        if (cmd_i.settle) begin
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
        end
        if (cmd_i.emit) begin
            m_tdata_reg <= {uvlt_pkg::COUNT_W'(count_reg), res_found_reg, res_status_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the storage depth");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(shift_wr && ins_wr_en))
        else $error("shift write and insert write in the same cycle");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.settle && (op_reg == uvlt_pkg::CMD_INSERT) && (res_status_next == uvlt_pkg::ST_OK))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("successful insert did not grow the count by one");
`endif

endmodule

[rtl/core/uvlt_ctrl.sv]
// Controller state machine of the unique value list table.
module uvlt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  uvlt_pkg::uvlt_stat_t stat_i,
    output uvlt_pkg::uvlt_cmd_t  cmd_o
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_tvalid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        cmd_o.load   = 1'b0;
        cmd_o.step   = 1'b0;
        cmd_o.settle = 1'b0;
        cmd_o.emit   = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_o.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat_i.instant) begin
                    cmd_o.settle = 1'b1;
                    state_next   = S_DONE;
                end else if (stat_i.use_shift) begin
                    state_next = S_SHIFT;
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH, S_SHIFT: begin
                if (stat_i.walk_done) begin
                    cmd_o.settle = 1'b1;
                    state_next   = S_DONE;
                end else begin
                    cmd_o.step = 1'b1;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd_o.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd_o.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new transaction accepted while one is in progress");

    a_valid_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished command");
`endif

endmodule

[rtl/core/unique_value_list_table_unit.sv]
// Top level of the unique value list table: a list of distinct values with search and removal.
// A command needs no walk when an insert finds the table full or its value zero, a remove has a bad
// index, or the command code is unused; otherwise a lookup or insert searches from entry 0 up to the
// first match or the end, and a remove shifts the entries above the index down by one (count-index-1).
// Commands are handled one at a time: a new one is accepted again the cycle after the last result is
// loaded; a waiting result holds back the next result, and with it the acceptance after that.
// Reset (aresetn low, synchronous) empties the list and sets the capacity to 64; no clearing pass.
module unique_value_list_table_unit #(
    parameter int DEPTH = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tuser fields from bit 0 up: cmd[1:0]
    input  logic [uvlt_pkg::CMD_W-1:0]      s_tuser,
    // s_tdata fields from bit 0 up: value[31:0], index[37:32], zero fill [39:38]
    input  logic [uvlt_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: status[2:0], found_index[8:3], entry_count[15:9]
    output logic [uvlt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [uvlt_pkg::CAP_W-1:0]      cfg_wdata
);

    uvlt_pkg::uvlt_cmd_t  cmd;
    uvlt_pkg::uvlt_stat_t stat;

    // Sequencing of each command.
    uvlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    // Storage, comparison and result formatting.
    uvlt_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .stat_o    (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

[tb/sv/unique_value_list_table_unit_test.sv]
// Self-checking testbench for the unique value list table with directed and random commands.
`timescale 1ns / 1ps

module unique_value_list_table_unit_test;
    import uvlt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int POOL_SIZE    = 80;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 204;
    // Quiet time after the last answer, long enough for the longest walk of DEPTH entries.
    localparam int SETTLE_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // Command code that the block must treat as a no-op.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Result fields, laid out exactly as m_tdata packs them.
    typedef struct packed {
        logic [COUNT_W-1:0]  entry_count;
        logic [FOUND_W-1:0]  found_index;
        logic [STATUS_W-1:0] status;
    } answer_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  index;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 22;

    // Directed rows run from reset with the reset capacity of 64.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_LOOKUP, 32'd5,          6'd0,  1'b1, ST_NOTFOUND, 6'd0, 7'd0},
        '{CMD_REMOVE, 32'd0,          6'd0,  1'b1, ST_BADIDX,   6'd0, 7'd0},
        '{CMD_UNUSED, 32'd7,          6'd3,  1'b1, ST_OK,       6'd0, 7'd0},
        '{CMD_INSERT, 32'd0,          6'd0,  1'b1, ST_ZERO,     6'd0, 7'd0},
        '{CMD_INSERT, 32'h8000_0000,  6'd0,  1'b1, ST_OK,       6'd0, 7'd1},
        '{CMD_INSERT, 32'h7fff_ffff,  6'd0,  1'b1, ST_OK,       6'd0, 7'd2},
        '{CMD_INSERT, 32'hffff_ffff,  6'd63, 1'b1, ST_OK,       6'd0, 7'd3},
        '{CMD_INSERT, 32'h8000_0000,  6'd0,  1'b1, ST_DUP,      6'd0, 7'd3},
        '{CMD_LOOKUP, 32'd0,          6'd0,  1'b1, ST_NOTFOUND, 6'd0, 7'd3},
        '{CMD_LOOKUP, 32'hffff_ffff,  6'd0,  1'b1, ST_OK,       6'd2, 7'd3},
        '{CMD_LOOKUP, 32'h8000_0000,  6'd63, 1'b1, ST_OK,       6'd0, 7'd3},
        '{CMD_REMOVE, 32'd0,          6'd63, 1'b1, ST_BADIDX,   6'd0, 7'd3},
        '{CMD_REMOVE, 32'd0,          6'd3,  1'b1, ST_BADIDX,   6'd0, 7'd3},
        '{CMD_REMOVE, 32'hffff_ffff,  6'd0,  1'b1, ST_OK,       6'd0, 7'd2},
        '{CMD_LOOKUP, 32'hffff_ffff,  6'd0,  1'b1, ST_OK,       6'd1, 7'd2},
        '{CMD_INSERT, 32'h5555_5555,  6'd0,  1'b0, ST_OK,       6'd0, 7'd0},
        '{CMD_INSERT, 32'haaaa_aaaa,  6'd0,  1'b0, ST_OK,       6'd0, 7'd0},
        '{CMD_UNUSED, 32'hffff_ffff,  6'd63, 1'b1, ST_OK,       6'd0, 7'd4},
        '{CMD_LOOKUP, 32'haaaa_aaaa,  6'd0,  1'b0, ST_OK,       6'd0, 7'd0},
        '{CMD_REMOVE, 32'd0,          6'd3,  1'b1, ST_OK,       6'd0, 7'd3},
        '{CMD_REMOVE, 32'd0,          6'd1,  1'b0, ST_OK,       6'd0, 7'd0},
        '{CMD_REMOVE, 32'd0,          6'd0,  1'b0, ST_OK,       6'd0, 7'd0}
    };

    // Capacity and insert share for each random phase; extremes are 0, 1, 64 and 127.
    localparam logic [CAP_W-1:0] PHASE_CAPACITY [PHASES] = '{
        7'd127, 7'd1, 7'd0, 7'd64, 7'd9, 7'd127, 7'd33, 7'd2, 7'd64
    };
    localparam int PHASE_INSERT_PCT [PHASES] = '{70, 40, 45, 60, 50, 70, 45, 40, 55};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CMD_W-1:0]     s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [CAP_W-1:0]     cfg_wdata;

    // Predicted contents of the table and its capacity register.
    logic [VALUE_W-1:0] stored_values [DEPTH];
    int                 stored_count;
    logic [CAP_W-1:0]   capacity_setting;

    logic [VALUE_W-1:0] value_pool [POOL_SIZE];
    answer_t            answers_due [$];
    int                 mismatch_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int unsigned        cycle_count = 0;

    unique_value_list_table_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Searches the stored entries in order for the first match.
    function automatic logic find_stored(input logic [VALUE_W-1:0] key, output int pos);
        pos = 0;
        for (int i = 0; i < stored_count; i++) begin
            if (stored_values[i] == key) begin
                pos = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one command to the predicted table and returns the answer it produces.
    function automatic answer_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [VALUE_W-1:0] value,
                                                   input logic [INDEX_W-1:0] index);
        answer_t ans;
        int      cap;
        int      pos;
        ans = '0;
        ans.status = ST_OK;
        cap = (capacity_setting > DEPTH) ? DEPTH : int'(capacity_setting);
        case (cmd)
            CMD_INSERT: begin
                if (stored_count >= cap) begin
                    ans.status = ST_FULL;
                end else if (value == '0) begin
                    ans.status = ST_ZERO;
                end else if (find_stored(value, pos)) begin
                    ans.status = ST_DUP;
                end else begin
                    stored_values[stored_count] = value;
                    stored_count++;
                end
            end
            CMD_LOOKUP: begin
                if (find_stored(value, pos)) begin
                    ans.found_index = pos[FOUND_W-1:0];
                end else begin
                    ans.status = ST_NOTFOUND;
                end
            end
            CMD_REMOVE: begin
                if (int'(index) >= stored_count) begin
                    ans.status = ST_BADIDX;
                end else begin
                    // Close the gap while keeping the order of later entries.
                    for (int i = int'(index); i + 1 < stored_count; i++) begin
                        stored_values[i] = stored_values[i + 1];
                    end
                    stored_count--;
                end
            end
            default: begin
            end
        endcase
        ans.entry_count = stored_count[COUNT_W-1:0];
        return ans;
    endfunction

    // Presents one command and records its expected answer once the transaction is accepted.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                                input logic [INDEX_W-1:0] index, input logic typed,
                                input answer_t typed_answer);
        answer_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, index, value};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predicted = apply_list_command(cmd, value, index);
        answers_due.push_back(typed ? typed_answer : predicted);
        @(negedge aclk);
    endtask

    // Builds a random command biased toward values that are, or were, in the table.
    task automatic send_random_command(input int insert_pct);
        int                 roll;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) begin
            cmd = CMD_INSERT;
        end else if (roll < insert_pct + 25) begin
            cmd = CMD_LOOKUP;
        end else if (roll < insert_pct + 28) begin
            cmd = CMD_UNUSED;
        end else begin
            cmd = CMD_REMOVE;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            value = '0;
        end else if (roll < 64) begin
            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (roll < 80 && stored_count > 0) begin
            value = stored_values[$urandom_range(0, stored_count - 1)];
        end else begin
            value = $urandom;
        end
        if (stored_count > 0 && $urandom_range(0, 99) < 80) begin
            index = INDEX_W'($urandom_range(0, stored_count - 1));
        end else begin
            index = INDEX_W'($urandom_range(0, DEPTH - 1));
        end
        send_command(cmd, value, index, 1'b0, '0);
    endtask

    // Holds off the sender until every expected answer has arrived and the block is quiet.
    task automatic wait_for_answers;
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // The receiver stalls at random according to the current idle share.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare every accepted result transaction with the oldest expected answer.
    always @(posedge aclk) begin
        answer_t got;
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = answer_t'(m_tdata);
            if (answers_due.size() == 0) begin
                $error("result transaction with no command outstanding: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, got.found_index);
                    mismatch_count++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        answer_t typed_answer;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            stored_values[i] = '0;
        end
        stored_count     = 0;
        capacity_setting = CAP_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: empty table, field extremes, every command and each error code but FULL.
        send_idle_pct = 33;
        recv_idle_pct = 61;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            typed_answer.status      = DIRECTED[r].status;
            typed_answer.found_index = DIRECTED[r].found_index;
            typed_answer.entry_count = DIRECTED[r].entry_count;
            send_command(DIRECTED[r].cmd, DIRECTED[r].value, DIRECTED[r].index,
                         DIRECTED[r].typed, typed_answer);
        end

        // Random phases, each with a set capacity, a new value pool and an idle pattern shared by groups of three.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_answers();
            cfg_we    <= 1'b1;
            cfg_wdata <= PHASE_CAPACITY[p];
            @(negedge aclk);
            cfg_we <= 1'b0;
            capacity_setting = PHASE_CAPACITY[p];
            case (p / 3)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < POOL_SIZE; i++) begin
                value_pool[i] = $urandom;
            end
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7fff_ffff;
            value_pool[2] = 32'hffff_ffff;
            repeat (PHASE_ITEMS) send_random_command(PHASE_INSERT_PCT[p]);
        end

        wait_for_answers();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
